/* hw/rtl/ftprp_pkg.sv */
// Shared types and constants for the FTP reply and passive address parser.
// No dependencies; the other files of the block import it, save ftprp_byte_stage.
package ftprp_pkg;

    // Result status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_CODE_ERR = 2'd1;
    localparam logic [1:0] STATUS_ADDR_ERR = 2'd2;

    // Address kinds.
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_IPV4 = 2'd1;
    localparam logic [1:0] KIND_PORT = 2'd2;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXT_PASV_EN   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ADDR_PARSE_EN = 2'd1;

    // Characters of interest.
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_DASH     = 8'h2D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CTRL_LIMIT  = 8'h20;

    // Reply codes with a passive address.
    localparam logic [9:0] CODE_PASV = 10'd227;
    localparam logic [9:0] CODE_EPSV = 10'd229;

    // Digit group limits.
    localparam int unsigned GROUP_W     = 17;
    localparam int unsigned GROUP_COUNT = 6;
    localparam logic [GROUP_W-1:0] GROUP_BYTE_MAX = 17'd255;
    localparam logic [GROUP_W-1:0] GROUP_PORT_MAX = 17'd65535;
    localparam logic [GROUP_W-1:0] GROUP_SAT      = 17'd131071;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  reply_code;
        logic [1:0]  address_kind;
        logic [31:0] ipv4_address;
        logic [15:0] data_port;
    } result_t;

endpackage

/* hw/rtl/ftprp_byte_stage.sv */
// Input register of the reply parser: holds one received word until the
// parser consumes it. Does not use ftprp_pkg (no imports).
module ftprp_byte_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    input  logic       blocked,
    output logic       step,
    output logic [7:0] byte_out
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       accept;

    assign step     = valid_reg && !blocked;
    assign rx_stall = valid_reg && blocked;
    assign accept   = rx_valid && !rx_stall;
    assign byte_out = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (step)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= rx_byte;
        end
    end

endmodule

/* hw/rtl/ftprp_reply_parser.sv */
// Reply state tracker: code digits, multi-line matching and digit groups.
// Produces one result at the final LF of a reply. Depends on ftprp_pkg.
module ftprp_reply_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        byte_in,
    input  logic              ext_pasv_en,
    input  logic              addr_parse_en,
    output logic              res_fire,
    output ftprp_pkg::result_t res
);
    import ftprp_pkg::*;

    logic [2:0]         pos_reg,    pos_next;
    logic [9:0]         code_reg,   code_next;
    logic [23:0]        digits_reg, digits_next;
    logic               cm_reg,     cm_next;
    logic               multi_reg,  multi_next;
    logic               err_reg,    err_next;
    logic               tend_reg,   tend_next;
    logic               ing_reg,    ing_next;
    logic [2:0]         gcnt_reg,   gcnt_next;
    logic [GROUP_W-1:0] gval_reg  [GROUP_COUNT];
    logic [GROUP_W-1:0] gval_next [GROUP_COUNT];

    logic               is_digit;
    logic [3:0]         digit;
    logic [2:0]         cnt_upd;
    logic [2:0]         gidx;
    logic [20:0]        gsum;
    logic [13:0]        csum;
    logic [7:0]         want;
    logic               fire;
    logic               clear;
    logic               ok_pasv;
    result_t            fin;
    result_t            res_c;

    assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
    assign digit    = byte_in[3:0];
    assign gidx     = cnt_upd - 3'd1;
    assign gsum     = {4'b0, gval_reg[gidx]} * 21'd10 + {17'b0, digit};
    assign csum     = {4'b0, code_reg} * 14'd10 + {10'b0, digit};

    always_comb
    begin
        case (pos_reg)
            3'd0:    want = digits_reg[23:16];
            3'd1:    want = digits_reg[15:8];
            default: want = digits_reg[7:0];
        endcase
    end

    // Completed reply: check the collected groups against the code.
    always_comb
    begin
        ok_pasv = (gcnt_reg == 3'd6);
        for (int i = 0; i < GROUP_COUNT; i++)
        begin
            if (gval_reg[i] > GROUP_BYTE_MAX)
            begin
                ok_pasv = 1'b0;
            end
        end
        fin = '0;
        fin.reply_code = code_reg;
        if (addr_parse_en && (code_reg == CODE_PASV))
        begin
            if (ok_pasv)
            begin
                fin.status       = STATUS_OK;
                fin.address_kind = KIND_IPV4;
                fin.ipv4_address = {gval_reg[0][7:0], gval_reg[1][7:0],
                                    gval_reg[2][7:0], gval_reg[3][7:0]};
                fin.data_port    = {gval_reg[4][7:0], gval_reg[5][7:0]};
            end
            else
            begin
                fin.status = STATUS_ADDR_ERR;
            end
        end
        else if (addr_parse_en && ext_pasv_en && (code_reg == CODE_EPSV))
        begin
            if ((gcnt_reg == 3'd1) && (gval_reg[0] <= GROUP_PORT_MAX))
            begin
                fin.status       = STATUS_OK;
                fin.address_kind = KIND_PORT;
                fin.data_port    = gval_reg[0][15:0];
            end
            else
            begin
                fin.status = STATUS_ADDR_ERR;
            end
        end
        else
        begin
            fin.status = STATUS_OK;
        end
    end

    always_comb
    begin
        pos_next    = pos_reg;
        code_next   = code_reg;
        digits_next = digits_reg;
        cm_next     = cm_reg;
        multi_next  = multi_reg;
        err_next    = err_reg;
        tend_next   = tend_reg;
        ing_next    = ing_reg;
        gcnt_next   = gcnt_reg;
        cnt_upd     = gcnt_reg;
        for (int i = 0; i < GROUP_COUNT; i++)
        begin
            gval_next[i] = gval_reg[i];
        end
        fire  = 1'b0;
        clear = 1'b0;
        res_c = fin;

        if (!multi_reg)
        begin
            if (pos_reg < 3'd3)
            begin
                if (!is_digit || ((pos_reg == 3'd0) && (byte_in == CH_ZERO)))
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    code_next   = csum[9:0];
                    digits_next = {digits_reg[15:0], byte_in};
                end
            end
            else if (pos_reg == 3'd3)
            begin
                if (is_digit)
                begin
                    err_next = 1'b1;
                end
                cm_next = (byte_in == CH_DASH);
                if (byte_in < CTRL_LIMIT)
                begin
                    tend_next = 1'b1;
                end
            end
            else if (!tend_reg)
            begin
                if (byte_in < CTRL_LIMIT)
                begin
                    tend_next = 1'b1;
                    ing_next  = 1'b0;
                end
                else if (is_digit)
                begin
                    if (!ing_reg)
                    begin
                        ing_next = 1'b1;
                        if (gcnt_reg < 3'd7)
                        begin
                            cnt_upd = gcnt_reg + 3'd1;
                        end
                    end
                    gcnt_next = cnt_upd;
                    if ((cnt_upd >= 3'd1) && (cnt_upd <= 3'd6))
                    begin
                        for (int i = 0; i < GROUP_COUNT; i++)
                        begin
                            if (gidx == 3'(i))
                            begin
                                gval_next[i] = (gsum > {4'b0, GROUP_SAT}) ?
                                               GROUP_SAT : gsum[GROUP_W-1:0];
                            end
                        end
                    end
                end
                else
                begin
                    ing_next = 1'b0;
                end
            end
        end
        else
        begin
            if (pos_reg < 3'd3)
            begin
                if (byte_in != want)
                begin
                    cm_next = 1'b0;
                end
            end
            else if (pos_reg == 3'd3)
            begin
                if (byte_in != CH_SPACE)
                begin
                    cm_next = 1'b0;
                end
            end
        end

        if (byte_in != CH_LF)
        begin
            if (pos_reg < 3'd7)
            begin
                pos_next = pos_reg + 3'd1;
            end
        end
        else if (!multi_reg)
        begin
            if (err_next)
            begin
                fire  = 1'b1;
                clear = 1'b1;
                res_c = '0;
                res_c.status = STATUS_CODE_ERR;
            end
            else if (cm_next)
            begin
                multi_next = 1'b1;
                pos_next   = 3'd0;
            end
            else
            begin
                fire  = 1'b1;
                clear = 1'b1;
            end
        end
        else if ((pos_reg >= 3'd4) && cm_next)
        begin
            fire  = 1'b1;
            clear = 1'b1;
        end
        else
        begin
            pos_next = 3'd0;
            cm_next  = 1'b1;
        end

        // Every result leaves the tracker ready for the next reply.
        if (clear)
        begin
            pos_next    = '0;
            code_next   = '0;
            digits_next = '0;
            cm_next     = 1'b0;
            multi_next  = 1'b0;
            err_next    = 1'b0;
            tend_next   = 1'b0;
            ing_next    = 1'b0;
            gcnt_next   = '0;
            for (int i = 0; i < GROUP_COUNT; i++)
            begin
                gval_next[i] = '0;
            end
        end
    end

    assign res_fire = step && fire;
    assign res      = res_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            code_reg   <= '0;
            digits_reg <= '0;
            cm_reg     <= 1'b0;
            multi_reg  <= 1'b0;
            err_reg    <= 1'b0;
            tend_reg   <= 1'b0;
            ing_reg    <= 1'b0;
            gcnt_reg   <= '0;
            for (int i = 0; i < GROUP_COUNT; i++)
            begin
                gval_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            pos_reg    <= pos_next;
            code_reg   <= code_next;
            digits_reg <= digits_next;
            cm_reg     <= cm_next;
            multi_reg  <= multi_next;
            err_reg    <= err_next;
            tend_reg   <= tend_next;
            ing_reg    <= ing_next;
            gcnt_reg   <= gcnt_next;
            for (int i = 0; i < GROUP_COUNT; i++)
            begin
                gval_reg[i] <= gval_next[i];
            end
        end
    end

endmodule

/* hw/rtl/ftprp_out_reg.sv */
// Result register: holds one finished reply word until the consumer takes it.
// Depends on ftprp_pkg for the result type.
module ftprp_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  ftprp_pkg::result_t din,
    output logic               blocked,
    output logic               res_valid,
    input  logic               res_stall,
    output ftprp_pkg::result_t dout
);
    import ftprp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign blocked   = valid_reg && res_stall;
    assign res_valid = valid_reg;
    assign dout      = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= din;
        end
    end

endmodule

/* hw/rtl/ftp_reply_passive_address_parser.sv */
// Top level of the FTP reply parser with passive address extraction.
// Depends on ftprp_pkg, ftprp_byte_stage, ftprp_reply_parser and ftprp_out_reg.

// This block takes the control connection one byte word per cycle, unless the
// input is stalled, and emits one result word for each complete reply, at the LF
// that ends it. A reply whose first line does not open with three digits (first
// digit not zero) and a non-digit separator is reported with status 1 at the end
// of that line. A dash separator opens a multi-line reply that ends at the first
// later line starting with the same code and a space. When address parsing is
// enabled, for code 227 the first line's text must carry six digit groups of at
// most 255 each, giving an IPv4 address and a port; for code 229, when extended
// passive parsing is enabled, exactly one group of at most 65535 gives the port.
// Failing these checks yields status 2 with the code kept. Throughput is one byte
// per cycle while the result is not stalled: the byte waits in the input
// register, and the reply state update and the result register load happen at
// the same edge. The loop over the tracker registers sets the rate.
// While a result waits in the output register, the next byte is still taken into
// the input register; the input stalls only when both registers are occupied and
// the result is stalled.
// Configuration registers are read when a reply completes and are meant to be
// written while the block is idle; cfg_ready is always high.
module ftp_reply_passive_address_parser (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             rx_valid,
    output logic                             rx_stall,
    input  logic [7:0]                       rx_byte,
    output logic                             res_valid,
    input  logic                             res_stall,
    output logic [1:0]                       status,
    output logic [9:0]                       reply_code,
    output logic [1:0]                       address_kind,
    output logic [31:0]                      ipv4_address,
    output logic [15:0]                      data_port,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ftprp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic                             cfg_data
);
    import ftprp_pkg::*;

    logic       ext_pasv_en_reg;
    logic       addr_parse_en_reg;
    logic       step;
    logic       blocked;
    logic [7:0] byte_cur;
    logic       res_fire;
    result_t    res_word;
    result_t    out_word;

    // Configuration port: always ready, writes to unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_pasv_en_reg   <= 1'b1;
            addr_parse_en_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_EXT_PASV_EN:   ext_pasv_en_reg   <= cfg_data;
                CFG_ADDR_PARSE_EN: addr_parse_en_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // The input register holds a byte until the tracker can advance, which is
    // any cycle in which the output register is free or being drained.
    ftprp_byte_stage u_byte_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_stall (rx_stall),
        .rx_byte  (rx_byte),
        .blocked  (blocked),
        .step     (step),
        .byte_out (byte_cur)
    );

    ftprp_reply_parser u_reply_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .byte_in       (byte_cur),
        .ext_pasv_en   (ext_pasv_en_reg),
        .addr_parse_en (addr_parse_en_reg),
        .res_fire      (res_fire),
        .res           (res_word)
    );

    ftprp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_fire),
        .din       (res_word),
        .blocked   (blocked),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .dout      (out_word)
    );

    assign status       = out_word.status;
    assign reply_code   = out_word.reply_code;
    assign address_kind = out_word.address_kind;
    assign ipv4_address = out_word.ipv4_address;
    assign data_port    = out_word.data_port;

endmodule
